/* rtl/mm_pkg.sv */
// Shared types and constants of the modular multiplier.
package mm_pkg;

	// Operation of one cell in the chain
	localparam logic [1:0] KIND_REDUCE = 2'd0;
	localparam logic [1:0] KIND_DOUBLE = 2'd1;
	localparam logic [1:0] KIND_ADD    = 2'd2;

	typedef struct packed {
		logic valid;
		logic zero;
	} ctl_t;

endpackage

/* rtl/mm_in_if.sv */
// Operand channel: multiplicand, multiplier and modulus with valid/ready.
interface mm_in_if #(
	parameter int WIDTH = 64
);
	logic             valid;
	logic             ready;
	logic [WIDTH-1:0] multiplicand;
	logic [WIDTH-1:0] multiplier;
	logic [WIDTH-1:0] modulus;

	modport source (output valid, multiplicand, multiplier, modulus, input ready);
	modport sink   (input valid, multiplicand, multiplier, modulus, output ready);
endinterface

/* rtl/mm_out_if.sv */
// Result channel: residue and zero-modulus flag with valid/ready.
interface mm_out_if #(
	parameter int WIDTH = 64
);
	logic             valid;
	logic             ready;
	logic [WIDTH-1:0] residue;
	logic             zero_modulus;

	modport source (output valid, residue, zero_modulus, input ready);
	modport sink   (input valid, residue, zero_modulus, output ready);
endinterface

/* rtl/modular_multiply.sv */
// An accepted request passes through every cell register of the chain and then the output register.
// Throughput: one request per cycle while the skid entry is empty; the chain of 3*WIDTH cells advances together.
// The first WIDTH cells reduce the multiplicand, the rest alternate double and add.
// A two-entry output stage keeps taking requests while one result waits; input stalls once the skid entry fills.
// Reset (arst_n, asynchronous, active low) clears all valid flags; no data is kept.
module modular_multiply #(
	parameter int WIDTH = 64
) (
	input  logic    clk,
	input  logic    arst_n,
	mm_in_if.sink   operands,
	mm_out_if.source result
);

	localparam int NCELL = 3 * WIDTH;

	mm_pkg::ctl_t     ctl_w  [NCELL+1];
	logic [WIDTH-1:0] r_w    [NCELL+1];
	logic [WIDTH-1:0] m_w    [NCELL+1];
	logic [WIDTH-1:0] x_w    [NCELL+1];
	logic [WIDTH-1:0] bits_w [NCELL+1];

	logic             en;
	logic             skid_valid_q;
	logic [WIDTH-1:0] skid_res_q;
	logic             skid_zero_q;
	logic             out_valid_q;
	logic [WIDTH-1:0] out_res_q;
	logic             out_zero_q;
	logic [WIDTH-1:0] tail_res;
	mm_pkg::ctl_t     tail_ctl;

	// chain advances unless the skid entry is holding a result
	assign en             = !skid_valid_q;
	assign operands.ready = en;

	assign ctl_w[0].valid = operands.valid;
	assign ctl_w[0].zero  = (operands.modulus == '0);
	assign r_w[0]         = '0;
	assign m_w[0]         = operands.modulus;
	assign x_w[0]         = operands.multiplier;
	assign bits_w[0]      = operands.multiplicand;

	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		logic [1:0]       kind;
		logic [WIDTH-1:0] prev_r, prev_x, prev_bits;

		if (i < WIDTH) begin : g_red
			assign kind      = mm_pkg::KIND_REDUCE;
			assign prev_r    = r_w[i];
			assign prev_x    = x_w[i];
			assign prev_bits = bits_w[i];
		end else if (i == WIDTH) begin : g_hand
			// remainder becomes the reduced factor, multiplier bits take over
			assign kind      = mm_pkg::KIND_DOUBLE;
			assign prev_r    = '0;
			assign prev_x    = r_w[i];
			assign prev_bits = x_w[i];
		end else begin : g_mul
			assign kind      = ((i - WIDTH) % 2 == 0) ? mm_pkg::KIND_DOUBLE
			                                           : mm_pkg::KIND_ADD;
			assign prev_r    = r_w[i];
			assign prev_x    = x_w[i];
			assign prev_bits = bits_w[i];
		end

		mm_cell #(.WIDTH(WIDTH)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.kind      (kind),
			.prev_ctl  (ctl_w[i]),
			.prev_r    (prev_r),
			.prev_m    (m_w[i]),
			.prev_x    (prev_x),
			.prev_bits (prev_bits),
			.ctl       (ctl_w[i+1]),
			.r         (r_w[i+1]),
			.m         (m_w[i+1]),
			.x         (x_w[i+1]),
			.bits      (bits_w[i+1])
		);
	end

	assign tail_ctl = ctl_w[NCELL];
	assign tail_res = tail_ctl.zero ? '0 : r_w[NCELL];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (result.ready || !out_valid_q) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= tail_ctl.valid;
			end
		end else if (tail_ctl.valid) begin
			// output stalled: park the arriving result
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (result.ready || !out_valid_q) begin
			if (skid_valid_q) begin
				out_res_q  <= skid_res_q;
				out_zero_q <= skid_zero_q;
			end else begin
				out_res_q  <= tail_res;
				out_zero_q <= tail_ctl.zero;
			end
		end else if (en) begin
			skid_res_q  <= tail_res;
			skid_zero_q <= tail_ctl.zero;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.residue      = out_res_q;
	assign result.zero_modulus = out_zero_q;

endmodule

/* rtl/mm_cell.sv */
// One cell of the chain: a single modular shift, double or add step.
module mm_cell #(
	parameter int WIDTH = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic [1:0]        kind,
	input  mm_pkg::ctl_t      prev_ctl,
	input  logic [WIDTH-1:0]  prev_r,
	input  logic [WIDTH-1:0]  prev_m,
	input  logic [WIDTH-1:0]  prev_x,
	input  logic [WIDTH-1:0]  prev_bits,
	output mm_pkg::ctl_t      ctl,
	output logic [WIDTH-1:0]  r,
	output logic [WIDTH-1:0]  m,
	output logic [WIDTH-1:0]  x,
	output logic [WIDTH-1:0]  bits
);

	mm_pkg::ctl_t     ctl_q;
	logic [WIDTH-1:0] r_q, m_q, x_q, bits_q;

	logic [WIDTH-1:0] addend;
	logic             cin;
	logic [WIDTH-1:0] bits_nxt;
	logic [WIDTH:0]   sum;
	logic [WIDTH:0]   diff;
	logic [WIDTH-1:0] r_nxt;

	always_comb begin
		addend   = '0;
		cin      = 1'b0;
		bits_nxt = prev_bits;
		case (kind)
			mm_pkg::KIND_REDUCE: begin
				// shift the next dividend bit into the remainder
				addend   = prev_r;
				cin      = prev_bits[WIDTH-1];
				bits_nxt = {prev_bits[WIDTH-2:0], 1'b0};
			end
			mm_pkg::KIND_DOUBLE: begin
				addend = prev_r;
			end
			mm_pkg::KIND_ADD: begin
				addend   = prev_bits[WIDTH-1] ? prev_x : '0;
				bits_nxt = {prev_bits[WIDTH-2:0], 1'b0};
			end
			default: begin
				addend = '0;
			end
		endcase
		// both terms are below the modulus, so one subtract brings it back in range
		sum   = {1'b0, prev_r} + {1'b0, addend} + {{WIDTH{1'b0}}, cin};
		diff  = sum - {1'b0, prev_m};
		r_nxt = (sum >= {1'b0, prev_m}) ? diff[WIDTH-1:0] : sum[WIDTH-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (en) begin
			ctl_q <= prev_ctl;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_q    <= r_nxt;
			m_q    <= prev_m;
			x_q    <= prev_x;
			bits_q <= bits_nxt;
		end
	end

	assign ctl  = ctl_q;
	assign r    = r_q;
	assign m    = m_q;
	assign x    = x_q;
	assign bits = bits_q;

endmodule

/* rtl/mm_checker.sv */
// Port-level checks of the modular multiplier and their binding.
module mm_checker #(
	parameter int WIDTH = 64
) (
	input logic             clk,
	input logic             arst_n,
	input logic             in_ready,
	input logic             res_valid,
	input logic             res_ready,
	input logic [WIDTH-1:0] residue,
	input logic             zero_modulus
);

	a_zero_res: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && zero_modulus |-> residue == '0)
		else $error("zero modulus with nonzero residue");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(residue) && $stable(zero_modulus))
		else $error("stalled result changed");

	a_busy_out: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> res_valid)
		else $error("input stalled with no result pending");

	a_busy_why: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_ready) |-> $past(res_valid && !res_ready))
		else $error("input stalled without output backpressure");

endmodule

bind modular_multiply mm_checker #(.WIDTH(WIDTH)) u_mm_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_ready     (operands.ready),
	.res_valid    (result.valid),
	.res_ready    (result.ready),
	.residue      (result.residue),
	.zero_modulus (result.zero_modulus)
);
